FILE: design/bua_pkg.sv
// Package for the bitmap unit allocator: request and response structs,
// action codes, register indexes, status codes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package bua_pkg;

    // Field widths fixed by the interface
    localparam int ACTION_W  = 2;
    localparam int OFFSET_W  = 17;
    localparam int COUNT_W   = 12;
    localparam int UNIT_W    = 6;
    localparam int HEADER_W  = 13;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 13;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_FORMAT = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    localparam logic [CFG_IDX_W-1:0] REG_UNIT_BYTES   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam logic [UNIT_W-1:0]   UNIT_BYTES_RESET   = 6'd2;
    localparam logic [HEADER_W-1:0] HEADER_BYTES_RESET = 13'd304;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [OFFSET_W-1:0] byte_offset;
    } t_alloc_req;

    typedef struct packed {
        logic                status;
        logic [OFFSET_W-1:0] unit_offset;
        logic [COUNT_W-1:0]  free_units;
        logic [COUNT_W-1:0]  total_units;
        logic                all_free;
    } t_alloc_rsp;

endpackage

FILE: design/bitmap_unit_allocator_top.sv
// Top level of the bitmap unit allocator: sequencer, shared restoring divider,
// free bitmap memory and counters. Depends on bua_pkg.
`timescale 1ns / 1ps

// Usage: pulse start with a request on i_req while busy is low; the request is
// taken at that clock edge and busy rises until the response is delivered,
// unless it is a no-op or an allocate with zero free units. The response
// appears on o_rsp for exactly one cycle with o_done high; busy is low in that
// same cycle, so a new transaction may be started right away. Configuration
// writes (i_cfg_we, i_cfg_idx, i_cfg_data) are taken at any edge; new register
// values are used by the next format, the unit size also by allocate and free.
// Steps from the start edge to o_done:
//   allocate: per bitmap word scanned, one memory read and one check; then a
//             byte search over up to eight bytes of the hit word, then a write
//             and a multiply step.
//   free:     the bit-serial divider, a setup state, then a read-modify-write
//             of one word; a free beyond the slab ends after the setup state.
//   format:   the divider, a setup state and one word write per bitmap word.
//   no-op, or allocate with zero free units: answered straight from idle.
// The divider and the one-port bitmap memory set this sequence of steps.
// After reset the block formats itself with the reset register values; busy
// stays high until that format ends and no response is produced.
// The receiver cannot stall; every response is delivered in its one cycle.

module bitmap_unit_allocator_top #(
    parameter int NUM_UNITS = 2048,
    parameter int MAP_WORDS = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  bua_pkg::t_alloc_req                    i_req,
    output logic                                   o_done,
    output bua_pkg::t_alloc_rsp                    o_rsp,
    input  logic                                   i_cfg_we,
    input  logic [bua_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [bua_pkg::CFG_DAT_W-1:0]          i_cfg_data
);

    localparam int MAP_BITS = MAP_WORDS * 64;
    localparam int CAP      = (NUM_UNITS < MAP_BITS) ? NUM_UNITS : MAP_BITS;
    localparam int WORD_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int UIDX_W   = WORD_W + 6;
    localparam int CNT_W    = UIDX_W + 1;
    localparam int PROD_W   = UIDX_W + bua_pkg::UNIT_W;
    localparam int DIV_STEPS = bua_pkg::OFFSET_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);

    localparam logic [bua_pkg::OFFSET_W-1:0] CAP_Q    = bua_pkg::OFFSET_W'(CAP);
    localparam logic [CNT_W-1:0]             CAP_C    = CNT_W'(CAP);
    localparam logic [WORD_W-1:0]            LAST_WORD = WORD_W'(MAP_WORDS - 1);
    localparam logic [STEP_W-1:0]            LAST_STEP = STEP_W'(DIV_STEPS - 1);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_DIV_END,
        S_FMT_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND,
        S_ALLOC_WR,
        S_MUL,
        S_FREE_RD,
        S_FREE_WR
    } t_state;

    // Control state
    t_state                         r_state,        n_state;
    logic                           r_done,         n_done;
    logic                           r_silent,       n_silent;
    logic [bua_pkg::UNIT_W-1:0]     r_unit_bytes,   n_unit_bytes;
    logic [bua_pkg::HEADER_W-1:0]   r_header_bytes, n_header_bytes;
    logic [CNT_W-1:0]               r_free,         n_free;
    logic [CNT_W-1:0]               r_total,        n_total;

    // Datapath registers
    logic [bua_pkg::ACTION_W-1:0]   r_action,       n_action;
    logic [bua_pkg::OFFSET_W-1:0]   r_quo,          n_quo;
    logic [bua_pkg::UNIT_W-1:0]     r_rem,          n_rem;
    logic [STEP_W-1:0]              r_step,         n_step;
    logic [CNT_W-1:0]               r_hdr,          n_hdr;
    logic [WORD_W-1:0]              r_word,         n_word;
    logic [2:0]                     r_byte,         n_byte;
    logic [63:0]                    r_buf,          n_buf;
    logic [UIDX_W-1:0]              r_uidx,         n_uidx;
    bua_pkg::t_alloc_rsp            r_rsp,          n_rsp;

    // Bitmap memory
    logic [63:0]                    r_mem [0:MAP_WORDS-1];
    logic [63:0]                    r_rdata;
    logic                           mem_we;
    logic [63:0]                    mem_wdata;

    // Combinational helpers
    logic [bua_pkg::UNIT_W-1:0]     ub;
    logic [bua_pkg::UNIT_W:0]       rem_sh;
    logic [bua_pkg::UNIT_W:0]       rem_diff;
    logic                           rem_ge;
    logic [bua_pkg::OFFSET_W-1:0]   fmt_dividend;
    logic [7:0]                     cur_byte;
    logic [CNT_W-1:0]               word_base;
    logic [PROD_W-1:0]              prod;
    logic [PROD_W+bua_pkg::OFFSET_W-1:0] prod_ext;
    logic                           finish;
    logic                           fin_status;
    logic [bua_pkg::OFFSET_W-1:0]   fin_offset;
    logic [CNT_W+bua_pkg::COUNT_W-1:0] free_ext;
    logic [CNT_W+bua_pkg::COUNT_W-1:0] total_ext;

    // Bits j of a word at unit index base for which base + j < lim.
    function automatic logic [63:0] below_mask(input logic [CNT_W-1:0] lim,
                                               input logic [CNT_W-1:0] base);
        logic [CNT_W-1:0] d;
        d = lim - base;
        if (lim <= base) begin
            return 64'd0;
        end else if (d >= CNT_W'(64)) begin
            return {64{1'b1}};
        end else begin
            return ~({64{1'b1}} << d[5:0]);
        end
    endfunction

    // Position of the lowest set bit of a byte.
    function automatic logic [2:0] lowest_bit(input logic [7:0] v);
        logic [2:0] pos;
        pos = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (v[k]) begin
                pos = 3'(k);
            end
        end
        return pos;
    endfunction

    assign ub           = (r_unit_bytes == '0) ? bua_pkg::UNIT_W'(1) : r_unit_bytes;
    assign fmt_dividend = bua_pkg::OFFSET_W'({1'b0, r_header_bytes} + 14'(ub) - 14'd1);
    assign rem_sh       = {r_rem, r_quo[bua_pkg::OFFSET_W-1]};
    assign rem_diff     = rem_sh - {1'b0, ub};
    assign rem_ge       = (rem_sh >= {1'b0, ub});
    assign cur_byte     = r_buf[{r_byte, 3'b000} +: 8];
    assign word_base    = {1'b0, r_word, 6'b000000};
    assign prod         = PROD_W'(r_uidx) * PROD_W'(ub);
    assign prod_ext     = {{bua_pkg::OFFSET_W{1'b0}}, prod};

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_comb begin
        n_state        = r_state;
        n_silent       = r_silent;
        n_unit_bytes   = r_unit_bytes;
        n_header_bytes = r_header_bytes;
        n_free         = r_free;
        n_total        = r_total;
        n_action       = r_action;
        n_quo          = r_quo;
        n_rem          = r_rem;
        n_step         = r_step;
        n_hdr          = r_hdr;
        n_word         = r_word;
        n_byte         = r_byte;
        n_buf          = r_buf;
        n_uidx         = r_uidx;
        mem_we         = 1'b0;
        mem_wdata      = r_rdata;
        finish         = 1'b0;
        fin_status     = bua_pkg::STATUS_OK;
        fin_offset     = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                bua_pkg::REG_UNIT_BYTES:   n_unit_bytes   = i_cfg_data[bua_pkg::UNIT_W-1:0];
                bua_pkg::REG_HEADER_BYTES: n_header_bytes = i_cfg_data[bua_pkg::HEADER_W-1:0];
                default: ;
            endcase
        end

        case (r_state)
            S_INIT: begin
                n_action = bua_pkg::ACT_FORMAT;
                n_quo    = fmt_dividend;
                n_rem    = '0;
                n_step   = '0;
                n_state  = S_DIV;
            end
            S_IDLE: begin
                if (start) begin
                    n_action = i_req.action;
                    n_rem    = '0;
                    n_step   = '0;
                    n_word   = '0;
                    case (i_req.action)
                        bua_pkg::ACT_ALLOC: begin
                            if (r_free == '0) begin
                                finish     = 1'b1;
                                fin_status = bua_pkg::STATUS_FULL;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        bua_pkg::ACT_FREE: begin
                            n_quo   = i_req.byte_offset;
                            n_state = S_DIV;
                        end
                        bua_pkg::ACT_FORMAT: begin
                            n_quo   = fmt_dividend;
                            n_state = S_DIV;
                        end
                        default: begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            S_DIV: begin
                // One quotient bit per cycle; the dividend shifts out of r_quo.
                if (rem_ge) begin
                    n_rem = rem_diff[bua_pkg::UNIT_W-1:0];
                end else begin
                    n_rem = rem_sh[bua_pkg::UNIT_W-1:0];
                end
                n_quo  = {r_quo[bua_pkg::OFFSET_W-2:0], rem_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    n_state = S_DIV_END;
                end
            end
            S_DIV_END: begin
                if (r_action == bua_pkg::ACT_FORMAT) begin
                    n_hdr   = (r_quo >= CAP_Q) ? CAP_C : r_quo[CNT_W-1:0];
                    n_word  = '0;
                    n_state = S_FMT_WR;
                end else if (r_quo < CAP_Q) begin
                    n_uidx  = r_quo[UIDX_W-1:0];
                    n_word  = r_quo[UIDX_W-1:6];
                    n_state = S_FREE_RD;
                end else begin
                    finish = 1'b1;
                end
            end
            S_FMT_WR: begin
                mem_we    = 1'b1;
                mem_wdata = below_mask(CAP_C, word_base) & ~below_mask(r_hdr, word_base);
                if (r_word == LAST_WORD) begin
                    n_total = CAP_C - r_hdr;
                    n_free  = CAP_C - r_hdr;
                    finish  = 1'b1;
                end else begin
                    n_word = r_word + WORD_W'(1);
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_rdata != 64'd0) begin
                    n_buf   = r_rdata;
                    n_byte  = '0;
                    n_state = S_FIND;
                end else if (r_word == LAST_WORD) begin
                    finish     = 1'b1;
                    fin_status = bua_pkg::STATUS_FULL;
                end else begin
                    n_word  = r_word + WORD_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_FIND: begin
                // The word is nonzero, so a byte with a set bit is always reached.
                if (cur_byte != 8'd0) begin
                    n_uidx  = {r_word, r_byte, lowest_bit(cur_byte)};
                    n_state = S_ALLOC_WR;
                end else begin
                    n_byte = r_byte + 3'd1;
                end
            end
            S_ALLOC_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_buf & ~(64'd1 << r_uidx[5:0]);
                n_free    = r_free - CNT_W'(1);
                n_state   = S_MUL;
            end
            S_MUL: begin
                finish     = 1'b1;
                fin_offset = prod_ext[bua_pkg::OFFSET_W-1:0];
            end
            S_FREE_RD: begin
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata | (64'd1 << r_uidx[5:0]);
                if (r_free < r_total) begin
                    n_free = r_free + CNT_W'(1);
                end
                finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (finish) begin
            n_state  = S_IDLE;
            n_silent = 1'b0;
        end
        n_done    = finish && !r_silent;
        free_ext  = {{bua_pkg::COUNT_W{1'b0}}, n_free};
        total_ext = {{bua_pkg::COUNT_W{1'b0}}, n_total};
        n_rsp.status      = fin_status;
        n_rsp.unit_offset = fin_offset;
        n_rsp.free_units  = free_ext[bua_pkg::COUNT_W-1:0];
        n_rsp.total_units = total_ext[bua_pkg::COUNT_W-1:0];
        n_rsp.all_free    = (n_free == n_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_done         <= 1'b0;
            r_silent       <= 1'b1;
            r_unit_bytes   <= bua_pkg::UNIT_BYTES_RESET;
            r_header_bytes <= bua_pkg::HEADER_BYTES_RESET;
            r_free         <= '0;
            r_total        <= '0;
        end else begin
            r_state        <= n_state;
            r_done         <= n_done;
            r_silent       <= n_silent;
            r_unit_bytes   <= n_unit_bytes;
            r_header_bytes <= n_header_bytes;
            r_free         <= n_free;
            r_total        <= n_total;
        end
        r_action <= n_action;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_hdr    <= n_hdr;
        r_word   <= n_word;
        r_byte   <= n_byte;
        r_buf    <= n_buf;
        r_uidx   <= n_uidx;
        if (finish) begin
            r_rsp <= n_rsp;
        end
    end

    // Single-port bitmap memory with a registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_word] <= mem_wdata;
        end
        r_rdata <= r_mem[r_word];
    end

endmodule

FILE: sim/bitmap_unit_allocator_top_tb.sv
// Self-checking testbench for the bitmap unit allocator: a queue-fed driver,
// a response monitor and a transaction-level predictor of the free bitmap and counts.
// Depends on bua_pkg and bitmap_unit_allocator_top.
`timescale 1ns / 1ps

module bitmap_unit_allocator_top_tb;

    localparam int NUM_UNITS       = 2048;
    localparam int MAP_WORDS       = 32;
    localparam int SLAB_UNITS      = (NUM_UNITS < 64 * MAP_WORDS) ? NUM_UNITS : 64 * MAP_WORDS;
    localparam int RAND_PHASES     = 12;
    localparam int ITEMS_PER_PHASE = 138;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 100;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    bua_pkg::t_alloc_req           i_req = '0;
    logic                          o_done;
    bua_pkg::t_alloc_rsp           o_rsp;
    logic                          i_cfg_we = 1'b0;
    logic [bua_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [bua_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    // Predictor state: configuration as written, bitmap and counters.
    logic [bua_pkg::UNIT_W-1:0]    cfg_unit;
    logic [bua_pkg::HEADER_W-1:0]  cfg_header;
    logic [63:0]                   free_map [MAP_WORDS];
    logic [bua_pkg::COUNT_W-1:0]   avail_cnt;
    logic [bua_pkg::COUNT_W-1:0]   total_cnt;

    bua_pkg::t_alloc_req           pending_reqs [$];
    bua_pkg::t_alloc_rsp           expected_rsp [$];
    bit                            gaps_on = 1'b1;
    int unsigned                   mismatch_count = 0;
    int unsigned                   stall_cycles = 0;

    bitmap_unit_allocator_top #(
        .NUM_UNITS (NUM_UNITS),
        .MAP_WORDS (MAP_WORDS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // A zero unit size counts as one; the header rounds up and never exceeds the slab.
    function automatic int unsigned header_units(int unsigned unit_raw, int unsigned hdr_raw);
        int unsigned ub;
        int unsigned hdr;
        ub = (unit_raw == 0) ? 1 : unit_raw;
        hdr = (hdr_raw + ub - 1) / ub;
        return (hdr > SLAB_UNITS) ? SLAB_UNITS : hdr;
    endfunction

    function automatic void format_slab();
        int unsigned hdr;
        hdr = header_units(cfg_unit, cfg_header);
        for (int w = 0; w < MAP_WORDS; w++) free_map[w] = '0;
        for (int u = hdr; u < SLAB_UNITS; u++) free_map[u / 64][u % 64] = 1'b1;
        total_cnt = bua_pkg::COUNT_W'(SLAB_UNITS - hdr);
        avail_cnt = total_cnt;
    endfunction

    function automatic bua_pkg::t_alloc_rsp apply_request(bua_pkg::t_alloc_req req);
        bua_pkg::t_alloc_rsp rsp;
        int unsigned         ub;
        int unsigned         idx;
        bit                  found;
        rsp = '0;
        rsp.status = bua_pkg::STATUS_OK;
        ub = (cfg_unit == 0) ? 1 : cfg_unit;
        found = 1'b0;
        case (req.action)
            bua_pkg::ACT_ALLOC: begin
                if (avail_cnt != 0) begin
                    for (int u = 0; u < SLAB_UNITS && !found; u++) begin
                        if (free_map[u / 64][u % 64]) begin
                            free_map[u / 64][u % 64] = 1'b0;
                            rsp.unit_offset = bua_pkg::OFFSET_W'(u * ub);
                            found = 1'b1;
                        end
                    end
                end
                if (found) begin
                    avail_cnt = avail_cnt - 1'b1;
                end else begin
                    rsp.status = bua_pkg::STATUS_FULL;
                end
            end
            bua_pkg::ACT_FREE: begin
                idx = req.byte_offset / ub;
                if (idx < SLAB_UNITS) begin
                    free_map[idx / 64][idx % 64] = 1'b1;
                    // Double frees are not detected, but the count stops at the total.
                    if (avail_cnt < total_cnt) avail_cnt = avail_cnt + 1'b1;
                end
            end
            bua_pkg::ACT_FORMAT: format_slab();
            default: ;
        endcase
        rsp.free_units = avail_cnt;
        rsp.total_units = total_cnt;
        rsp.all_free = (avail_cnt == total_cnt);
        return rsp;
    endfunction

    // Driver: holds start while busy, otherwise presents the next pending request or drops start.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) expected_rsp.push_back(apply_request(i_req));
            if (!start || !busy) begin
                if (pending_reqs.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 36)) begin
                    start <= 1'b1;
                    i_req <= pending_reqs.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed response must match the oldest expectation.
    always @(posedge i_clk) begin
        bua_pkg::t_alloc_rsp want;
        if (i_rst_n && o_done) begin
            if (expected_rsp.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display({"unexpected response: status=%0d offset=%0d free=%0d",
                              " total=%0d all_free=%0d"},
                             o_rsp.status, o_rsp.unit_offset, o_rsp.free_units,
                             o_rsp.total_units, o_rsp.all_free);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.unit_offset !== want.unit_offset ||
                    o_rsp.free_units !== want.free_units ||
                    o_rsp.total_units !== want.total_units ||
                    o_rsp.all_free !== want.all_free) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"response mismatch: expected status=%0d offset=%0d",
                                  " free=%0d total=%0d all_free=%0d, got status=%0d",
                                  " offset=%0d free=%0d total=%0d all_free=%0d"},
                                 want.status, want.unit_offset, want.free_units,
                                 want.total_units, want.all_free,
                                 o_rsp.status, o_rsp.unit_offset, o_rsp.free_units,
                                 o_rsp.total_units, o_rsp.all_free);
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("bitmap_unit_allocator_top regression: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [bua_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bua_pkg::CFG_DAT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == bua_pkg::REG_UNIT_BYTES) begin
            cfg_unit = data[bua_pkg::UNIT_W-1:0];
        end else begin
            cfg_header = data[bua_pkg::HEADER_W-1:0];
        end
    endtask

    task automatic queue_item(input bua_pkg::t_action act,
                              input logic [bua_pkg::OFFSET_W-1:0] offs);
        bua_pkg::t_alloc_req req;
        req.action = act;
        req.byte_offset = offs;
        pending_reqs.push_back(req);
    endtask

    task automatic wait_drain();
        while (pending_reqs.size() != 0 || start || expected_rsp.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned                   ub_raw;
        int unsigned                   hdr_raw;
        int unsigned                   ub;
        int unsigned                   hdr_units;
        int unsigned                   since_fmt;
        int unsigned                   r;
        int unsigned                   t;
        logic [bua_pkg::CFG_DAT_W-1:0] cfg_word;
        logic [bua_pkg::OFFSET_W-1:0]  offs;

        cfg_unit = bua_pkg::UNIT_BYTES_RESET;
        cfg_header = bua_pkg::HEADER_BYTES_RESET;
        format_slab();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // The block formats itself after reset; nothing is issued until it is idle.
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Reset formatting, header-unit frees that saturate, frees beyond the slab.
        queue_item(bua_pkg::ACT_NOP, 17'h1ffff);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h1ffff);
        queue_item(bua_pkg::ACT_FREE, 17'd304);
        queue_item(bua_pkg::ACT_FREE, 17'd0);
        queue_item(bua_pkg::ACT_FREE, 17'd2);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_FREE, 17'd98303);
        queue_item(bua_pkg::ACT_FREE, 17'h1ffff);
        wait_drain();

        // Unit size zero behaves as one; no header at all.
        write_reg(bua_pkg::REG_UNIT_BYTES, '0);
        write_reg(bua_pkg::REG_HEADER_BYTES, '0);
        queue_item(bua_pkg::ACT_FORMAT, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_FREE, 17'd4095);
        queue_item(bua_pkg::ACT_FREE, 17'd2047);
        wait_drain();

        // Header larger than the slab leaves nothing to allocate.
        write_reg(bua_pkg::REG_UNIT_BYTES, bua_pkg::CFG_DAT_W'(1));
        write_reg(bua_pkg::REG_HEADER_BYTES, bua_pkg::CFG_DAT_W'(4096));
        queue_item(bua_pkg::ACT_FORMAT, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_FREE, 17'd5);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        wait_drain();

        // Three usable units; a double free leaves a count with no set bit behind it.
        write_reg(bua_pkg::REG_UNIT_BYTES, bua_pkg::CFG_DAT_W'(2));
        write_reg(bua_pkg::REG_HEADER_BYTES, bua_pkg::CFG_DAT_W'(4090));
        queue_item(bua_pkg::ACT_FORMAT, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_FREE, 17'd4094);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        wait_drain();

        // Largest odd unit size with the largest header value.
        write_reg(bua_pkg::REG_UNIT_BYTES, bua_pkg::CFG_DAT_W'(63));
        write_reg(bua_pkg::REG_HEADER_BYTES, bua_pkg::CFG_DAT_W'(8191));
        queue_item(bua_pkg::ACT_FORMAT, 17'h0);
        queue_item(bua_pkg::ACT_ALLOC, 17'h0);
        queue_item(bua_pkg::ACT_FREE, 17'd98303);
        queue_item(bua_pkg::ACT_NOP, 17'h0);
        wait_drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                ub_raw = 2 * $urandom_range(1, 24);
                hdr_raw = $urandom_range(0, 4096);
            end else if (r < 8) begin
                // Nearly the whole slab is header, so the free units run out quickly.
                ub_raw = $urandom_range(1, 4);
                t = $urandom_range(0, 40);
                hdr_raw = (2048 - t) * ub_raw - $urandom_range(0, ub_raw - 1);
                if (hdr_raw > 8191) hdr_raw = 8191;
            end else begin
                ub_raw = $urandom_range(0, 63);
                hdr_raw = $urandom_range(0, 8191);
            end
            cfg_word = bua_pkg::CFG_DAT_W'($urandom);
            cfg_word[bua_pkg::UNIT_W-1:0] = bua_pkg::UNIT_W'(ub_raw);
            if ($urandom_range(0, 1)) cfg_word[bua_pkg::CFG_DAT_W-1:bua_pkg::UNIT_W] = '0;
            write_reg(bua_pkg::REG_UNIT_BYTES, cfg_word);
            write_reg(bua_pkg::REG_HEADER_BYTES, bua_pkg::CFG_DAT_W'(hdr_raw));
            gaps_on = (p != 4);
            ub = (ub_raw == 0) ? 1 : ub_raw;
            hdr_units = header_units(ub_raw, hdr_raw);
            since_fmt = 0;
            if ($urandom_range(0, 4) != 0)
                queue_item(bua_pkg::ACT_FORMAT, bua_pkg::OFFSET_W'($urandom));

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 48) begin
                    queue_item(bua_pkg::ACT_ALLOC, bua_pkg::OFFSET_W'($urandom));
                    since_fmt++;
                end else if (r < 88) begin
                    r = $urandom_range(0, 99);
                    if (r < 70) begin
                        // Allocation is lowest-first, so live units sit just above the header.
                        offs = bua_pkg::OFFSET_W'(
                            (hdr_units + $urandom_range(0, since_fmt + 1)) * ub +
                            $urandom_range(0, ub - 1));
                    end else if (r < 85) begin
                        offs = bua_pkg::OFFSET_W'($urandom_range(0, hdr_units * ub));
                    end else begin
                        offs = bua_pkg::OFFSET_W'($urandom);
                    end
                    queue_item(bua_pkg::ACT_FREE, offs);
                end else if (r < 92) begin
                    queue_item(bua_pkg::ACT_FORMAT, bua_pkg::OFFSET_W'($urandom));
                    since_fmt = 0;
                end else begin
                    queue_item(bua_pkg::ACT_NOP, bua_pkg::OFFSET_W'($urandom));
                end
            end
            wait_drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0) begin
            $display("bitmap_unit_allocator_top regression: pass");
        end else begin
            $display("bitmap_unit_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
